>>> hdl/ech_pkg.sv
package ech_pkg;

  localparam int unsigned ROW_W      = 12;
  localparam int unsigned ELEV_W     = 24;
  localparam int unsigned SLOPE_W    = 18;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // scaled offset, its square, the radicand (padded to an even width) and the root
  localparam int unsigned PROD_W = ROW_W + LEN_W;
  localparam int unsigned SQ_W   = 2 * PROD_W;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned RAD_W  = SUM_W + (SUM_W % 2);
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;

  // drop = root * slope >> 16, then the signed height difference
  localparam int unsigned SLOPE_FRAC = 16;
  localparam int unsigned MULS_W     = ROOT_W + SLOPE_W;
  localparam int unsigned DROP_W     = MULS_W - SLOPE_FRAC;
  localparam int unsigned DIFF_W     = DROP_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_HEIGHT,
    CFG_SLOPE_RATIO,
    CFG_CENTRE_ROW,
    CFG_CENTRE_COL,
    CFG_CELL_WIDTH,
    CFG_CELL_HEIGHT
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ELEV_W-1:0]  source_height;
    logic        [SLOPE_W-1:0] slope_ratio;
    logic        [ROW_W-1:0]   centre_row;
    logic        [ROW_W-1:0]   centre_col;
    logic        [LEN_W-1:0]   cell_width;
    logic        [LEN_W-1:0]   cell_height;
  } cfg_t;

  // state that travels along the square root chain
  typedef struct packed {
    logic        [RAD_W-1:0]  rad;
    logic        [REM_W-1:0]  rem;
    logic        [ROOT_W-1:0] root;
    logic signed [ELEV_W-1:0] elev;
    logic                     oob;
  } sq_t;

endpackage

>>> hdl/ech_in_if.sv
interface ech_in_if import ech_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [ROW_W-1:0]  row;
  logic        [ROW_W-1:0]  col;
  logic signed [ELEV_W-1:0] elevation;

  modport source (output valid, output row, output col, output elevation, input ready);
  modport sink   (input valid, input row, input col, input elevation, output ready);
endinterface

>>> hdl/ech_out_if.sv
interface ech_out_if import ech_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] hazard_height;

  modport source (output valid, output hazard_height, input ready);
  modport sink   (input valid, input hazard_height, output ready);
endinterface

>>> hdl/ech_dist_front.sv
module ech_dist_front import ech_pkg::*; #(
  parameter int unsigned GRID_ROWS = 4096,
  parameter int unsigned GRID_COLS = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic        [ROW_W-1:0]  row_i,
  input  logic        [ROW_W-1:0]  col_i,
  input  logic signed [ELEV_W-1:0] elev_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output sq_t                      data_o
);

  localparam int unsigned NSTG = 4;
  localparam logic [ROW_W:0] ROW_LIM = (ROW_W + 1)'(GRID_ROWS);
  localparam logic [ROW_W:0] COL_LIM = (ROW_W + 1)'(GRID_COLS);

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;

  logic        [ROW_W-1:0]  adx_q, ady_q;
  logic        [PROD_W-1:0] dx_q, dy_q;
  logic        [SQ_W-1:0]   dx2_q, dy2_q;
  logic signed [ELEV_W-1:0] e0_q, e1_q, e2_q;
  logic                     oob0_q, oob1_q, oob2_q;
  sq_t                      out_q;

  // a stage loads when it is empty or its successor loads
  assign rdy[NSTG] = ready_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      adx_q  <= (col_i >= cfg_i.centre_col) ? col_i - cfg_i.centre_col
                                            : cfg_i.centre_col - col_i;
      ady_q  <= (row_i >= cfg_i.centre_row) ? row_i - cfg_i.centre_row
                                            : cfg_i.centre_row - row_i;
      e0_q   <= elev_i;
      oob0_q <= ({1'b0, row_i} >= ROW_LIM) || ({1'b0, col_i} >= COL_LIM);
    end
    if (rdy[1]) begin
      dx_q   <= PROD_W'(adx_q) * PROD_W'(cfg_i.cell_width);
      dy_q   <= PROD_W'(ady_q) * PROD_W'(cfg_i.cell_height);
      e1_q   <= e0_q;
      oob1_q <= oob0_q;
    end
    if (rdy[2]) begin
      dx2_q  <= SQ_W'(dx_q) * SQ_W'(dx_q);
      dy2_q  <= SQ_W'(dy_q) * SQ_W'(dy_q);
      e2_q   <= e1_q;
      oob2_q <= oob1_q;
    end
    if (rdy[3]) begin
      out_q.rad  <= RAD_W'(SUM_W'(dx2_q) + SUM_W'(dy2_q));
      out_q.rem  <= '0;
      out_q.root <= '0;
      out_q.elev <= e2_q;
      out_q.oob  <= oob2_q;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NSTG-1];
  assign data_o  = out_q;

endmodule

>>> hdl/ech_sqrt_cell.sv
module ech_sqrt_cell import ech_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  sq_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output sq_t  data_o
);

  logic             v_q;
  sq_t              d_q;
  sq_t              step;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  // one root digit: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh    = {data_i.rem[REM_W-3:0], data_i.rad[RAD_W-1 -: 2]};
    trial     = REM_W'({data_i.root, 2'b01});
    ge        = rem_sh >= trial;
    step      = data_i;
    step.rad  = data_i.rad << 2;
    step.rem  = ge ? rem_sh - trial : rem_sh;
    step.root = {data_i.root[ROOT_W-2:0], ge};
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) d_q <= step;
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

>>> hdl/ech_cone_back.sv
module ech_cone_back import ech_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  sq_t              data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [OUT_W-1:0] height_o
);

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic        [DROP_W-1:0] drop_q;
  logic signed [ELEV_W-1:0] elev_q;
  logic                     oob_q;
  logic        [OUT_W-1:0]  hh_q;
  logic        [MULS_W-1:0] prod;
  logic signed [DIFF_W-1:0] diff;
  logic        [OUT_W-1:0]  hh_d;

  assign rdy[2] = ready_i;
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign prod = MULS_W'(data_i.root) * MULS_W'(cfg_i.slope_ratio);

  always_comb begin
    diff = DIFF_W'(cfg_i.source_height) - $signed({2'b00, drop_q}) - DIFF_W'(elev_q);
    if (oob_q || diff[DIFF_W-1]) begin
      hh_d = '0;
    end else if (diff[DIFF_W-2:OUT_W] != '0) begin
      hh_d = '1;
    end else begin
      hh_d = diff[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      drop_q <= prod[MULS_W-1:SLOPE_FRAC];
      elev_q <= data_i.elev;
      oob_q  <= data_i.oob;
    end
    if (rdy[1]) hh_q <= hh_d;
  end

  assign ready_o  = rdy[0];
  assign valid_o  = v_q[1];
  assign height_o = hh_q;

endmodule

>>> hdl/energy_cone_hazard_height.sv
// Energy-cone hazard height for a stream of elevation-model cells. Each transfer on in_i
// carries one cell (row, column, elevation in cm); one transfer on out_o returns the
// height of the cone surface above that terrain, clamped at zero and saturated at the
// 24-bit maximum, in input order. Cells outside the GRID_ROWS x GRID_COLS grid give zero.
// The block takes a new cell every cycle unless a stalled output has filled it, and holds
// up to 35 cells in flight: four distance stages, then the square root, a chain of 29 cells
// that each resolve one root bit, then two slope/clamp stages. A stalled output only holds
// back stages that are full, so bubbles are squeezed out before input stops. Write the
// configuration registers only while no cell is in flight.
module energy_cone_hazard_height import ech_pkg::*; #(
  parameter int unsigned GRID_ROWS = 4096,
  parameter int unsigned GRID_COLS = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ech_in_if.sink                in_i,
  ech_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;

  // configuration registers; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_height <= '0;
      cfg_q.slope_ratio   <= '0;
      cfg_q.centre_row    <= '0;
      cfg_q.centre_col    <= '0;
      cfg_q.cell_width    <= LEN_W'(1);
      cfg_q.cell_height   <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SOURCE_HEIGHT: cfg_q.source_height <= $signed(cfg_data_i[ELEV_W-1:0]);
        CFG_SLOPE_RATIO:   cfg_q.slope_ratio   <= cfg_data_i[SLOPE_W-1:0];
        CFG_CENTRE_ROW:    cfg_q.centre_row    <= cfg_data_i[ROW_W-1:0];
        CFG_CENTRE_COL:    cfg_q.centre_col    <= cfg_data_i[ROW_W-1:0];
        CFG_CELL_WIDTH:    cfg_q.cell_width    <= cfg_data_i[LEN_W-1:0];
        CFG_CELL_HEIGHT:   cfg_q.cell_height   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // square root chain: index 0 is the front end output, ROOT_W the last cell
  sq_t  chain_data [ROOT_W+1];
  logic chain_v    [ROOT_W+1];
  logic chain_rdy  [ROOT_W+1];

  ech_dist_front #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .row_i   (in_i.row),
    .col_i   (in_i.col),
    .elev_i  (in_i.elevation),
    .valid_o (chain_v[0]),
    .ready_i (chain_rdy[0]),
    .data_o  (chain_data[0])
  );

  // each cell settles one root bit, most significant first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    ech_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[i]),
      .ready_o (chain_rdy[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_v[i+1]),
      .ready_i (chain_rdy[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // slope drop, subtraction and clamp; its last register is the output register
  ech_cone_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (chain_v[ROOT_W]),
    .ready_o  (chain_rdy[ROOT_W]),
    .data_i   (chain_data[ROOT_W]),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .height_o (out_o.hazard_height)
  );

endmodule

>>> hdl/ech_checker.sv
module ech_checker import ech_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] out_height_i
);

  // reset empties the pipeline, so no result is offered on the following edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result offered during reset");

  // every stage loads when the output is taken, so the input is open too
  a_ready_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input closed while output is being taken");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result withdrawn");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_height_i))
    else $error("stalled result changed");

endmodule

bind energy_cone_hazard_height ech_checker u_ech_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_height_i (out_o.hazard_height)
);

>>> test/energy_cone_hazard_height_tb.sv
module energy_cone_hazard_height_tb import ech_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_ROWS    = 4096;
  localparam int unsigned GRID_COLS    = 4096;
  localparam longint      ELEV_MIN     = -(longint'(1) <<< (ELEV_W - 1));
  localparam longint      ELEV_MAX     = (longint'(1) <<< (ELEV_W - 1)) - 1;
  localparam longint      HEIGHT_MAX   = (longint'(1) <<< OUT_W) - 1;
  localparam int unsigned ROW_LAST     = (1 << ROW_W) - 1;

  // register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);

  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_CELLS  = 150;
  localparam int unsigned BURST_PHASE  = 4;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_AFTER   = 600;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic        [ROW_W-1:0]  row;
    logic        [ROW_W-1:0]  col;
    logic signed [ELEV_W-1:0] elev;
  } cell_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ech_in_if  in_if ();
  ech_out_if out_if ();

  energy_cone_hazard_height #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow of the register file, updated as each write lands.
  cfg_t cone_cfg;

  cell_t            cell_q[$];    // cells waiting to be offered
  logic [OUT_W-1:0] height_q[$];  // predicted heights, oldest first

  int unsigned in_idle_pct  = IDLE_PCT;
  int unsigned out_idle_pct = IDLE_PCT;
  bit          offering     = 1'b0;  // driver is holding a cell on the input
  bit          in_took      = 1'b0;  // input transfer seen at the last rising edge
  int unsigned cells_sent   = 0;
  int unsigned heights_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned reg_writes   = 0;
  int unsigned settings     = 0;
  int unsigned stall_left   = 0;
  bit          hold_done    = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Truncated square root, settled one bit at a time from the top.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 30; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Height lost along the cone between the source cell and this one.
  function automatic longint unsigned cone_drop(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col);
    longint unsigned dx;
    longint unsigned dy;
    dx = (col >= cone_cfg.centre_col) ? 64'(col - cone_cfg.centre_col)
                                      : 64'(cone_cfg.centre_col - col);
    dy = (row >= cone_cfg.centre_row) ? 64'(row - cone_cfg.centre_row)
                                      : 64'(cone_cfg.centre_row - row);
    dx = dx * 64'(cone_cfg.cell_width);
    dy = dy * 64'(cone_cfg.cell_height);
    return (floor_root(dx * dx + dy * dy) * 64'(cone_cfg.slope_ratio)) >> SLOPE_FRAC;
  endfunction

  function automatic logic [OUT_W-1:0] cone_height(logic [ROW_W-1:0] row,
                                                  logic [ROW_W-1:0] col,
                                                  logic signed [ELEV_W-1:0] elev);
    longint s;
    // cells off the grid give nothing
    if (row >= GRID_ROWS || col >= GRID_COLS) return '0;
    s = longint'(signed'(cone_cfg.source_height)) - longint'(cone_drop(row, col))
        - longint'(elev);
    if (s < 0) return '0;
    if (s > HEIGHT_MAX) return '1;
    return s[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: change on the falling edge, advance only after a transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    cell_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end else if (!offering || in_took) begin
      if (cell_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = cell_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.row       <= nxt.row;
        in_if.col       <= nxt.col;
        in_if.elevation <= nxt.elev;
        offering = 1'b1;
      end else begin
        // idle: drop valid and scramble the payload, which must be ignored
        in_if.valid     <= 1'b0;
        in_if.row       <= ROW_W'($urandom);
        in_if.col       <= ROW_W'($urandom);
        in_if.elevation <= ELEV_W'($urandom);
        offering = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output receiver: random back-pressure, plus one long hold-off once enough
  // heights have come back so that the pipeline fills and stalls its input
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!hold_done && heights_seen >= HOLD_AFTER) begin
      stall_left = HOLD_CYCLES;
      hold_done  = 1'b1;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge, predict on each input
  // transfer and check each output transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        height_q.push_back(cone_height(in_if.row, in_if.col, in_if.elevation));
        cells_sent++;
      end
      if (out_if.valid && out_if.ready) begin
        if (height_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected hazard_height %0d with no cell outstanding",
                     out_if.hazard_height);
        end else begin
          want = height_q.pop_front();
          if (out_if.hazard_height !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("hazard_height mismatch on result %0d: expected %0d, got %0d",
                       heights_seen, want, out_if.hazard_height);
          end
        end
        heights_seen++;
      end
      // watchdog: count cycles in which nothing moves on either side
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_cell(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                          logic signed [ELEV_W-1:0] elev);
    cell_q.push_back('{row: row, col: col, elev: elev});
  endtask

  // Write one register and mirror it; spare indexes change nothing.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_SOURCE_HEIGHT: cone_cfg.source_height = data[ELEV_W-1:0];
      CFG_SLOPE_RATIO:   cone_cfg.slope_ratio   = data[SLOPE_W-1:0];
      CFG_CENTRE_ROW:    cone_cfg.centre_row    = data[ROW_W-1:0];
      CFG_CENTRE_COL:    cone_cfg.centre_col    = data[ROW_W-1:0];
      CFG_CELL_WIDTH:    cone_cfg.cell_width    = data[LEN_W-1:0];
      CFG_CELL_HEIGHT:   cone_cfg.cell_height   = data[LEN_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Write every register; bits above each register's width carry junk.
  task automatic set_config(logic signed [ELEV_W-1:0] src, logic [SLOPE_W-1:0] slope,
                            logic [ROW_W-1:0] crow, logic [ROW_W-1:0] ccol,
                            logic [LEN_W-1:0] cw, logic [LEN_W-1:0] ch);
    logic [CFG_DATA_W-1:0] d;
    d = src;
    write_reg(CFG_SOURCE_HEIGHT, d);
    d = CFG_DATA_W'($urandom);
    d[SLOPE_W-1:0] = slope;
    write_reg(CFG_SLOPE_RATIO, d);
    d = CFG_DATA_W'($urandom);
    d[ROW_W-1:0] = crow;
    write_reg(CFG_CENTRE_ROW, d);
    d = CFG_DATA_W'($urandom);
    d[ROW_W-1:0] = ccol;
    write_reg(CFG_CENTRE_COL, d);
    d = CFG_DATA_W'($urandom);
    d[LEN_W-1:0] = cw;
    write_reg(CFG_CELL_WIDTH, d);
    d = CFG_DATA_W'($urandom);
    d[LEN_W-1:0] = ch;
    write_reg(CFG_CELL_HEIGHT, d);
    settings++;
  endtask

  // Hold until every cell has gone in and every height has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cell_q.size() != 0 || offering || height_q.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(4))
      0:       return '0;
      1:       return LEN_W'(1);
      2:       return '1;
      3:       return LEN_W'($urandom_range(300, 1));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_centre();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return ROW_W'($urandom);
    endcase
  endfunction

  // Pick a position close to the source about half the time, so that the
  // cone surface is neither far above nor far below most cells.
  function automatic logic [ROW_W-1:0] pick_pos(logic [ROW_W-1:0] centre);
    int p;
    if ($urandom_range(1) == 0) return ROW_W'($urandom);
    p = int'(centre) + int'($urandom_range(128)) - 64;
    if (p < 0) p = 0;
    if (p > int'(ROW_LAST)) p = int'(ROW_LAST);
    return ROW_W'(p);
  endfunction

  initial begin
    logic signed [ELEV_W-1:0] rsrc;
    logic [SLOPE_W-1:0]       rslope;
    logic [ROW_W-1:0]         rr;
    logic [ROW_W-1:0]         cc;
    longint                   e;

    in_if.valid     = 1'b0;
    in_if.row       = '0;
    in_if.col       = '0;
    in_if.elevation = '0;
    out_if.ready    = 1'b0;
    cone_cfg        = '{source_height: '0, slope_ratio: '0, centre_row: '0,
                        centre_col: '0, cell_width: LEN_W'(1), cell_height: LEN_W'(1)};

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: flat cone at zero, so the height is minus the elevation.
    add_cell('0, '0, '0);
    add_cell('1, '1, ELEV_W'(ELEV_MIN));
    add_cell(ROW_W'(5), ROW_W'(7), ELEV_W'(ELEV_MAX));
    wait_idle();

    // Unit slope around an inner source cell: the full 24-bit maximum at the apex with the
    // lowest terrain, clamp with the highest, then the four grid corners and a neighbour.
    set_config(ELEV_W'(ELEV_MAX), SLOPE_W'(1 << SLOPE_FRAC), ROW_W'(100), ROW_W'(200),
               LEN_W'(100), LEN_W'(100));
    add_cell(ROW_W'(100), ROW_W'(200), ELEV_W'(ELEV_MIN));
    add_cell(ROW_W'(100), ROW_W'(200), ELEV_W'(ELEV_MAX));
    add_cell('0, '0, '0);
    add_cell('1, '1, '0);
    add_cell('0, '1, ELEV_W'(123456));
    add_cell('1, '0, -ELEV_W'(5000));
    add_cell(ROW_W'(101), ROW_W'(200), ELEV_W'(ELEV_MAX - 101));
    wait_idle();

    // Writes to the spare indexes must leave every register alone.
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    add_cell(ROW_W'(100), ROW_W'(201), '0);
    add_cell(ROW_W'(300), ROW_W'(50), -ELEV_W'(77));
    wait_idle();

    // Extremes: lowest apex, steepest slope, widest cells, source in a corner.
    set_config(ELEV_W'(ELEV_MIN), '1, '1, '1, '1, '1);
    add_cell('0, '0, ELEV_W'(ELEV_MIN));
    add_cell('0, '0, ELEV_W'(ELEV_MAX));
    add_cell('1, '1, ELEV_W'(ELEV_MIN));
    add_cell('1, '1, '0);
    wait_idle();

    // Zero cell width: only the row offset adds to the distance.
    set_config('0, SLOPE_W'(1 << (SLOPE_FRAC - 1)), '0, '0, '0, '1);
    add_cell(ROW_W'(2000), '1, -ELEV_W'(1000000));
    add_cell(ROW_W'(100), '0, '0);
    add_cell('0, '1, ELEV_W'(ELEV_MIN));
    wait_idle();

    // Random phases, each under a fresh setting.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      in_idle_pct  = (ph == BURST_PHASE) ? 0 : IDLE_PCT;
      out_idle_pct = (ph == BURST_PHASE) ? 0 : IDLE_PCT;
      case ($urandom_range(3))
        0:       rsrc = ELEV_W'(ELEV_MIN);
        1:       rsrc = ELEV_W'(ELEV_MAX);
        default: rsrc = ELEV_W'($urandom);
      endcase
      case ($urandom_range(4))
        0:       rslope = '0;
        1:       rslope = '1;
        2:       rslope = SLOPE_W'($urandom_range(2048));
        3:       rslope = SLOPE_W'($urandom_range(2 << SLOPE_FRAC));
        default: rslope = SLOPE_W'($urandom);
      endcase
      set_config(rsrc, rslope, pick_centre(), pick_centre(), pick_len(), pick_len());

      for (int unsigned k = 0; k < PHASE_CELLS; k++) begin
        rr = pick_pos(cone_cfg.centre_row);
        cc = pick_pos(cone_cfg.centre_col);
        case ($urandom_range(3))
          0: e = longint'(signed'(ELEV_W'($urandom)));
          3: e = $urandom_range(1) ? ELEV_MIN : ELEV_MAX;
          default: begin
            // terrain just above or below the cone surface
            e = longint'(signed'(cone_cfg.source_height)) - longint'(cone_drop(rr, cc))
                + longint'($urandom_range(2000)) - 1000;
          end
        endcase
        if (e < ELEV_MIN) e = ELEV_MIN;
        if (e > ELEV_MAX) e = ELEV_MAX;
        add_cell(rr, cc, e[ELEV_W-1:0]);
      end
    end

    // Drain, then give the pipeline its full latency to show any stray result.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d cells under %0d register settings (%0d writes, spare indexes too)",
             cells_sent, settings, reg_writes);
    $display("checked %0d heights with a %0d-cycle output hold-off and a burst with no idling",
             heights_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
